/* sv/axis_step_and_delay_planner_macros.svh */
// assertion helpers for the step planner
`ifndef AXIS_STEP_AND_DELAY_PLANNER_MACROS_SVH
`define AXIS_STEP_AND_DELAY_PLANNER_MACROS_SVH
`define ASDP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* sv/asdp_pkg.sv */
`default_nettype none
package asdp_pkg;
    typedef struct packed {
        logic signed [23:0] dist_x;
        logic signed [23:0] dist_y;
        logic signed [23:0] dist_z;
        logic [15:0]        feed_mm_min;
    } in_item_t;

    typedef struct packed {
        logic [23:0] steps_x;
        logic [23:0] steps_y;
        logic [23:0] steps_z;
        logic        dir_x;
        logic        dir_y;
        logic        dir_z;
        logic [31:0] delay_x_us;
        logic [31:0] delay_y_us;
        logic [31:0] delay_z_us;
    } out_item_t;

    typedef enum logic [2:0] {
        REG_SPM_X = 3'd0,
        REG_SPM_Y = 3'd1,
        REG_SPM_Z = 3'd2,
        REG_LIM_X = 3'd3,
        REG_LIM_Y = 3'd4,
        REG_LIM_Z = 3'd5
    } reg_idx_t;

    localparam int unsigned QW = 34;
    localparam logic [QW-1:0] DELAY_NUM = 34'd15360000000;
    localparam logic [31:0] DELAY_ZERO = 32'd500;
    localparam logic [31:0] DELAY_MIN = 32'd200;
    localparam logic [23:0] STEPS_MAX = 24'hFFFFFF;
    // restoring divider stages: one quotient bit per stage
    localparam int unsigned DIV_STAGES = QW;
    localparam int unsigned LATENCY = DIV_STAGES + 3;
endpackage
`default_nettype wire

/* sv/asdp_steps.sv */
`default_nettype none
// step count and direction for one axis, pipelined over the divider latency
module asdp_steps (
    input  wire logic               clk,
    input  wire logic signed [23:0] distance,
    input  wire logic [19:0]        spm,
    output logic [23:0]             steps,
    output logic                    dir
);
    localparam int unsigned DEPTH = asdp_pkg::LATENCY + 1;
    logic [23:0] mag_reg;
    logic        dir_reg;
    logic [19:0] spm_reg;
    logic [43:0] prod_reg;
    logic        pdir_reg;
    logic [44:0] rnd;
    logic [24:0] st;
    logic [23:0] sat;
    logic [23:0] pipe_s_reg [DEPTH-2];
    logic        pipe_d_reg [DEPTH-2];

    // magnitude and sign
    always_ff @(posedge clk)
    begin
        mag_reg  <= distance[23] ? 24'(-distance) : 24'(distance);
        dir_reg  <= ~distance[23];
        spm_reg  <= spm;
        prod_reg <= mag_reg * spm_reg;
        pdir_reg <= dir_reg;
    end

    // round half up and saturate
    always_comb
    begin
        rnd = {1'b0, prod_reg} + 45'(1 << 19);
        st  = rnd[44:20];
        sat = st[24] ? asdp_pkg::STEPS_MAX : st[23:0];
    end

    // delay line to match the divider
    always_ff @(posedge clk)
    begin
        pipe_s_reg[0] <= sat;
        pipe_d_reg[0] <= pdir_reg;
        for (int i = 1; i < DEPTH - 2; i++)
        begin
            pipe_s_reg[i] <= pipe_s_reg[i-1];
            pipe_d_reg[i] <= pipe_d_reg[i-1];
        end
    end

    assign steps = pipe_s_reg[DEPTH-3];
    assign dir   = pipe_d_reg[DEPTH-3];
endmodule
`default_nettype wire

/* sv/asdp_delay.sv */
`default_nettype none
// step interval for one axis: clamp, multiply, pipelined restoring divide
module asdp_delay (
    input  wire logic        clk,
    input  wire logic [15:0] feed,
    input  wire logic [19:0] spm,
    input  wire logic [31:0] lim,
    output logic [31:0]      delay
);
    localparam int unsigned N = asdp_pkg::QW;
    logic [15:0] f_reg;
    logic [19:0] spm_reg;
    logic [35:0] r_reg;
    logic [15:0] fc;
    logic [N-1:0] num_reg [N+1];
    logic [35:0]  den_reg [N+1];
    logic [36:0]  rem_reg [N+1];
    logic [N-1:0] quo_reg [N+1];
    logic [N:0]   zero_reg;
    logic [31:0]  out_reg;

    // feed clamp, max applied last
    always_comb
    begin
        fc = feed;
        if (fc < lim[15:0])
        begin
            fc = lim[15:0];
        end
        if (fc > lim[31:16])
        begin
            fc = lim[31:16];
        end
    end

    // clamp and multiply stages
    always_ff @(posedge clk)
    begin
        f_reg   <= fc;
        spm_reg <= spm;
        r_reg   <= f_reg * spm_reg;
    end

    // divider entry
    always_ff @(posedge clk)
    begin
        num_reg[0]  <= asdp_pkg::DELAY_NUM;
        den_reg[0]  <= r_reg;
        rem_reg[0]  <= '0;
        quo_reg[0]  <= '0;
        zero_reg[0] <= (r_reg == '0);
    end

    // one quotient bit per stage
    for (genvar k = 0; k < N; k++)
    begin : g_div
        logic [37:0] trial;
        logic [36:0] shifted;
        always_comb
        begin
            shifted = {rem_reg[k][35:0], num_reg[k][N-1-k]};
            trial   = {1'b0, shifted} - {2'b0, den_reg[k]};
        end
        always_ff @(posedge clk)
        begin
            num_reg[k+1]  <= num_reg[k];
            den_reg[k+1]  <= den_reg[k];
            zero_reg[k+1] <= zero_reg[k];
            if (!trial[37])
            begin
                rem_reg[k+1] <= trial[36:0];
                quo_reg[k+1] <= {quo_reg[k][N-2:0], 1'b1};
            end
            else
            begin
                rem_reg[k+1] <= shifted;
                quo_reg[k+1] <= {quo_reg[k][N-2:0], 1'b0};
            end
        end
    end

    // special cases and saturation
    always_ff @(posedge clk)
    begin
        if (zero_reg[N])
        begin
            out_reg <= asdp_pkg::DELAY_ZERO;
        end
        else if (quo_reg[N][N-1:32] != '0)
        begin
            out_reg <= 32'hFFFFFFFF;
        end
        else if (quo_reg[N][31:0] < asdp_pkg::DELAY_MIN)
        begin
            out_reg <= asdp_pkg::DELAY_MIN;
        end
        else
        begin
            out_reg <= quo_reg[N][31:0];
        end
    end

    assign delay = out_reg;
endmodule
`default_nettype wire

/* sv/axis_step_and_delay_planner.sv */
// an accepted start is carried to the done strobe by a valid-bit shift register beside the data
// throughput: one transaction per cycle, busy stays low
// interval set by a 34-stage restoring divider per axis, one quotient bit per stage
// reset: configuration registers return to defaults, pipeline valid bits clear
// results appear on a one-cycle done strobe; the receiver cannot stall
`default_nettype none
module axis_step_and_delay_planner (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire asdp_pkg::in_item_t  in_item,
    output logic                     done,
    output asdp_pkg::out_item_t      out_item,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data
);
    localparam int unsigned LAT = asdp_pkg::LATENCY + 1;
    logic [19:0] spm_x_reg, spm_y_reg, spm_z_reg;
    logic [31:0] lim_x_reg, lim_y_reg, lim_z_reg;
    logic [LAT-1:0] vld_reg;
    logic [31:0] dx, dy, dz;
    logic [23:0] sx, sy, sz;
    logic        rx, ry, rz;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spm_x_reg <= 20'd20480;
            spm_y_reg <= 20'd20480;
            spm_z_reg <= 20'd102400;
            lim_x_reg <= 32'd393216100;
            lim_y_reg <= 32'd393216100;
            lim_z_reg <= 32'd19660810;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                asdp_pkg::REG_SPM_X: spm_x_reg <= cfg_data[19:0];
                asdp_pkg::REG_SPM_Y: spm_y_reg <= cfg_data[19:0];
                asdp_pkg::REG_SPM_Z: spm_z_reg <= cfg_data[19:0];
                asdp_pkg::REG_LIM_X: lim_x_reg <= cfg_data;
                asdp_pkg::REG_LIM_Y: lim_y_reg <= cfg_data;
                asdp_pkg::REG_LIM_Z: lim_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // valid bits alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], start & ~busy};
        end
    end

    asdp_steps u_sx (.clk, .distance(in_item.dist_x), .spm(spm_x_reg),
        .steps(sx), .dir(rx));
    asdp_steps u_sy (.clk, .distance(in_item.dist_y), .spm(spm_y_reg),
        .steps(sy), .dir(ry));
    asdp_steps u_sz (.clk, .distance(in_item.dist_z), .spm(spm_z_reg),
        .steps(sz), .dir(rz));
    asdp_delay u_dx (.clk, .feed(in_item.feed_mm_min), .spm(spm_x_reg),
        .lim(lim_x_reg), .delay(dx));
    asdp_delay u_dy (.clk, .feed(in_item.feed_mm_min), .spm(spm_y_reg),
        .lim(lim_y_reg), .delay(dy));
    asdp_delay u_dz (.clk, .feed(in_item.feed_mm_min), .spm(spm_z_reg),
        .lim(lim_z_reg), .delay(dz));

    // result transaction
    assign done = vld_reg[LAT-1];
    always_comb
    begin
        out_item.steps_x    = sx;
        out_item.steps_y    = sy;
        out_item.steps_z    = sz;
        out_item.dir_x      = rx;
        out_item.dir_y      = ry;
        out_item.dir_z      = rz;
        out_item.delay_x_us = dx;
        out_item.delay_y_us = dy;
        out_item.delay_z_us = dz;
    end
endmodule
`default_nettype wire

/* sv/asdp_checker.sv */
`default_nettype none
`include "axis_step_and_delay_planner_macros.svh"
// port level checks for the planner
module asdp_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                done,
    input wire asdp_pkg::out_item_t out_item
);
    localparam int unsigned L = asdp_pkg::LATENCY + 1;
    // the block never holds off a command
    `ASDP_ASSERT_IMPL(a_never_busy, clk, rst_n, 1'b1, !busy)
    // every accepted transaction gives a done after the fixed latency
    `ASDP_ASSERT_NEXT(a_done_follows, clk, rst_n, start && !busy, ##(L-1) done)
    // no done without an accepted transaction behind it
    `ASDP_ASSERT_IMPL(a_done_has_origin, clk, rst_n, done, $past(start && !busy, L))
    // intervals never drop below the floor
    `ASDP_ASSERT_IMPL(a_delay_floor, clk, rst_n, done, (out_item.delay_x_us >= asdp_pkg::DELAY_MIN) && (out_item.delay_y_us >= asdp_pkg::DELAY_MIN) && (out_item.delay_z_us >= asdp_pkg::DELAY_MIN))
endmodule

bind axis_step_and_delay_planner asdp_checker u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .done(done),
    .out_item(out_item)
);
`default_nettype wire
